>>> src/fed_pkg.sv
`timescale 1ns / 1ps

package fed_pkg;

    // Sample format and ring size
    localparam int SAMPLE_BITS = 16;
    localparam int RING_DEPTH  = 65536;
    localparam int RING_AW     = $clog2(RING_DEPTH);

    // Register field widths
    localparam int GAIN_W     = 15;
    localparam int DELAY_W    = 15;
    localparam int CHAN_W     = 2;
    localparam int THR_W      = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    // Ring length arithmetic: (delay + 1) doubled for two channels
    localparam int RAW_LEN_W = DELAY_W + 2;
    localparam int LEN_W     = (RAW_LEN_W > RING_AW + 1) ? RAW_LEN_W : RING_AW + 1;

    // Feedback product and level sum
    localparam int PROD_W     = GAIN_W + 1 + SAMPLE_BITS;
    localparam int ROUND_BIAS = 1 << (GAIN_W - 1);
    localparam int SUM_W      = RING_AW + SAMPLE_BITS;
    localparam int CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;

    // Pipeline and result buffer
    localparam int PIPE_STAGES = 3;
    localparam int INFL_W      = $clog2(PIPE_STAGES + 1);
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = FIFO_AW + 1;
    localparam int OCC_W       = FIFO_AW + 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [RING_AW-1:0]            addr_t;
    typedef logic [LEN_W-1:0]              len_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEEDBACK_GAIN  = 2'd0,
        CFG_DELAY_FRAMES   = 2'd1,
        CFG_CHANNEL_COUNT  = 2'd2,
        CFG_TAIL_THRESHOLD = 2'd3
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = 15'd26214;
    localparam logic [DELAY_W-1:0] DELAY_RST = 15'd20000;
    localparam logic [CHAN_W-1:0]  CHAN_RST  = 2'd1;
    localparam logic [THR_W-1:0]   THR_RST   = 31'd6554;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0] delay;
        logic [CHAN_W-1:0]  chan;
        logic [THR_W-1:0]   thr;
    } cfg_t;

    // Request entering the datapath, with its two ring addresses
    typedef struct packed {
        logic    valid;
        addr_t   wp;
        addr_t   rd;
        sample_t x;
    } req_t;

    typedef struct packed {
        logic    we;
        addr_t   addr;
        sample_t data;
    } wr_t;

    typedef struct packed {
        logic  clr_busy;
        addr_t wp;
        len_t  len;
    } ring_status_t;

    typedef struct packed {
        sample_t out_sample;
        logic    tail;
    } result_t;

    // Clamp a value carrying two guard bits to the sample range
    function automatic sample_t sat_sample(input logic signed [SAMPLE_BITS+1:0] v);
        sample_t r;
        if ((v[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000) ||
            (v[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111))
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        else if (v[SAMPLE_BITS+1])
        begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> src/feedback_echo_delay.sv
`timescale 1ns / 1ps

// Path: a request accepted at one clock edge passes memory read, feedback
//   multiply, ring write and level sum before its result shows on the output.
// Throughput: one request per cycle outside the reset clearing sweep; the
//   eight-entry result buffer throttles intake only when the consumer stalls.
// Reset: registers return to defaults, pointer and level sum clear, and the
//   ring is zeroed by a sweep over all RING_DEPTH (65536) words with in_stall high.

module feedback_echo_delay (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [fed_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [fed_pkg::SAMPLE_BITS-1:0] in_sample,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fed_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                                 tail_active
);

    fed_pkg::cfg_t                    cfg;
    fed_pkg::req_t                    req;
    fed_pkg::wr_t                     dp_wr;
    fed_pkg::wr_t                     ram_wr;
    fed_pkg::ring_status_t            status;
    logic [fed_pkg::SAMPLE_BITS-1:0]  ram_rd_word;
    logic [fed_pkg::SAMPLE_BITS-1:0]  ram_wp_word;
    logic                             res_valid;
    fed_pkg::result_t                 res;
    fed_pkg::result_t                 head;
    logic [fed_pkg::INFL_W-1:0]       inflight;
    logic [fed_pkg::CNT_W-1:0]        fifo_count;
    logic [fed_pkg::OCC_W-1:0]        occupancy;
    logic                             accept;
    logic                             pop;

    // Register file: the user must write it only while the block is idle; the block itself does not enforce this
    fed_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pointer logic: ring length from the registers, the read slot one delay
    // behind the write slot for the same channel, and the power-up clearing sweep
    fed_ring_ctrl u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .in_sample (in_sample),
        .dp_wr     (dp_wr),
        .req       (req),
        .ram_wr    (ram_wr),
        .status    (status)
    );

    // Ring storage: port a reads the delayed word, port b the word being replaced
    fed_ram #(
        .WIDTH (fed_pkg::SAMPLE_BITS),
        .DEPTH (fed_pkg::RING_DEPTH)
    ) u_ring_mem (
        .clk     (clk),
        .we      (ram_wr.we),
        .waddr   (ram_wr.addr),
        .wdata   (ram_wr.data),
        .raddr_a (req.rd),
        .raddr_b (req.wp),
        .rdata_a (ram_rd_word),
        .rdata_b (ram_wp_word)
    );

    // Three-stage datapath; forwards its own pending writes around the memory
    fed_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rd_word   (ram_rd_word),
        .wp_word   (ram_wp_word),
        .wr        (dp_wr),
        .res_valid (res_valid),
        .res       (res),
        .inflight  (inflight)
    );

    // Result buffer decouples the consumer's stall from the pipeline
    fed_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    // Hold off new requests while clearing, or when every buffer slot is
    // already promised to a request in flight or a result waiting
    assign occupancy = fed_pkg::OCC_W'(fifo_count) + fed_pkg::OCC_W'(inflight);
    assign in_stall  = status.clr_busy ||
                       (occupancy >= fed_pkg::OCC_W'(fed_pkg::FIFO_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign out_valid   = (fifo_count != '0);
    assign pop         = out_valid && !out_stall;
    assign out_sample  = head.out_sample;
    assign tail_active = head.tail;

    // Credit scheme never overruns the result buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= fed_pkg::OCC_W'(fed_pkg::FIFO_DEPTH))
    else $error("result buffer overcommitted");

    // No request may be in flight while the sweep owns the write port
    assert property (@(posedge clk) disable iff (!rst_n)
        status.clr_busy |-> (inflight == '0))
    else $error("request in flight during ring clear");

    // Pointer stays inside the ring after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we) |=> (fed_pkg::LEN_W'(status.wp) < status.len))
    else $error("write pointer outside ring");

endmodule

>>> src/fed_ram.sv
`timescale 1ns / 1ps

module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> src/fed_cfg_regs.sv
`timescale 1ns / 1ps

module fed_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fed_pkg::cfg_t                     cfg
);

    fed_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain  <= fed_pkg::GAIN_RST;
            cfg_reg.delay <= fed_pkg::DELAY_RST;
            cfg_reg.chan  <= fed_pkg::CHAN_RST;
            cfg_reg.thr   <= fed_pkg::THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (fed_pkg::cfg_reg_t'(cfg_index))
                fed_pkg::CFG_FEEDBACK_GAIN:
                    cfg_reg.gain <= cfg_data[fed_pkg::GAIN_W-1:0];
                fed_pkg::CFG_DELAY_FRAMES:
                    cfg_reg.delay <= cfg_data[fed_pkg::DELAY_W-1:0];
                fed_pkg::CFG_CHANNEL_COUNT:
                    cfg_reg.chan <= cfg_data[fed_pkg::CHAN_W-1:0];
                fed_pkg::CFG_TAIL_THRESHOLD:
                    cfg_reg.thr <= cfg_data[fed_pkg::THR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/fed_ring_ctrl.sv
`timescale 1ns / 1ps

module fed_ring_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fed_pkg::cfg_t         cfg,
    input  logic                  accept,
    input  fed_pkg::sample_t      in_sample,
    input  fed_pkg::wr_t          dp_wr,
    output fed_pkg::req_t         req,
    output fed_pkg::wr_t          ram_wr,
    output fed_pkg::ring_status_t status
);

    localparam fed_pkg::addr_t LAST_ADDR = fed_pkg::RING_AW'(fed_pkg::RING_DEPTH - 1);

    fed_pkg::addr_t wp_reg;
    logic           clr_busy_reg;
    fed_pkg::addr_t clr_addr_reg;

    logic                              ch_two;
    logic [fed_pkg::RAW_LEN_W-1:0]     raw_len;
    fed_pkg::len_t                     raw_len_ext;
    fed_pkg::len_t                     len;
    fed_pkg::len_t                     ch_len;
    fed_pkg::len_t                     wp_eff;
    fed_pkg::len_t                     rd_sum;
    fed_pkg::len_t                     rd_pos;
    fed_pkg::len_t                     wp_inc;
    fed_pkg::len_t                     wp_next;

    // Ring length: (delay + 1) per channel, capped at RING_DEPTH; channel codes above one count as two
    always_comb
    begin
        ch_two      = cfg.chan[1];
        raw_len     = (fed_pkg::RAW_LEN_W'(cfg.delay) + fed_pkg::RAW_LEN_W'(1)) << ch_two;
        raw_len_ext = fed_pkg::LEN_W'(raw_len);
        len         = (raw_len_ext > fed_pkg::LEN_W'(fed_pkg::RING_DEPTH)) ?
                      fed_pkg::LEN_W'(fed_pkg::RING_DEPTH) : raw_len_ext;
        ch_len      = ch_two ? fed_pkg::LEN_W'(2) : fed_pkg::LEN_W'(1);

        // Restart a pointer left outside a shrunken ring
        wp_eff  = (fed_pkg::LEN_W'(wp_reg) >= len) ? '0 : fed_pkg::LEN_W'(wp_reg);
        rd_sum  = wp_eff + ch_len;
        rd_pos  = (rd_sum >= len) ? rd_sum - len : rd_sum;
        wp_inc  = wp_eff + fed_pkg::LEN_W'(1);
        wp_next = (wp_inc >= len) ? '0 : wp_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= fed_pkg::RING_AW'(wp_next);
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign req = '{valid: accept,
                   wp:    fed_pkg::RING_AW'(wp_eff),
                   rd:    fed_pkg::RING_AW'(rd_pos),
                   x:     in_sample};

    // Clearing sweep owns the write port until it ends
    assign ram_wr = clr_busy_reg ? '{we: 1'b1, addr: clr_addr_reg, data: '0} : dp_wr;

    assign status = '{clr_busy: clr_busy_reg, wp: wp_reg, len: len};

endmodule

>>> src/fed_datapath.sv
`timescale 1ns / 1ps

module fed_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fed_pkg::cfg_t                 cfg,
    input  fed_pkg::req_t                 req,
    input  fed_pkg::sample_t              rd_word,
    input  fed_pkg::sample_t              wp_word,
    output fed_pkg::wr_t                  wr,
    output logic                          res_valid,
    output fed_pkg::result_t              res,
    output logic [fed_pkg::INFL_W-1:0]    inflight
);

    localparam int SB = fed_pkg::SAMPLE_BITS;

    // Stage 1: ring words arrive from memory
    logic             s1_valid_reg;
    fed_pkg::addr_t   s1_wp_reg;
    fed_pkg::addr_t   s1_rd_reg;
    fed_pkg::sample_t s1_x_reg;

    // Write performed at the last edge, not yet seen by a same-edge read
    logic             wl_valid_reg;
    fed_pkg::addr_t   wl_addr_reg;
    fed_pkg::sample_t wl_data_reg;

    // Stage 2: ring write
    logic             s2_valid_reg;
    fed_pkg::addr_t   s2_wp_reg;
    fed_pkg::sample_t s2_w_reg;
    fed_pkg::sample_t s2_old_reg;
    fed_pkg::sample_t s2_out_reg;

    // Stage 3: level sum update
    logic                   s3_valid_reg;
    fed_pkg::sample_t       s3_out_reg;
    logic signed [SB:0]     s3_delta_reg;

    logic [fed_pkg::SUM_W-1:0] level_reg;
    logic [fed_pkg::SUM_W-1:0] level_next;

    fed_pkg::sample_t                  d;
    fed_pkg::sample_t                  old;
    logic signed [fed_pkg::PROD_W-1:0] prod;
    logic signed [fed_pkg::PROD_W-1:0] prod_rnd;
    logic signed [SB:0]                scaled;
    fed_pkg::sample_t                  w_next;
    fed_pkg::sample_t                  out_next;
    logic [SB-1:0]                     mag_w;
    logic [SB-1:0]                     mag_old;
    logic signed [SB:0]                delta_next;
    logic                              tail;

    // Forward writes still in flight over the memory words
    always_comb
    begin
        priority if (s2_valid_reg && (s2_wp_reg == s1_rd_reg))
        begin
            d = s2_w_reg;
        end
        else if (wl_valid_reg && (wl_addr_reg == s1_rd_reg))
        begin
            d = wl_data_reg;
        end
        else
        begin
            d = rd_word;
        end

        priority if (s2_valid_reg && (s2_wp_reg == s1_wp_reg))
        begin
            old = s2_w_reg;
        end
        else if (wl_valid_reg && (wl_addr_reg == s1_wp_reg))
        begin
            old = wl_data_reg;
        end
        else
        begin
            old = wp_word;
        end
    end

    // Feedback: round(gain * d / 2^15), ties up, then add and clamp
    always_comb
    begin
        prod     = $signed({1'b0, cfg.gain}) * d;
        prod_rnd = prod + fed_pkg::PROD_W'(fed_pkg::ROUND_BIAS);
        scaled   = prod_rnd[fed_pkg::PROD_W-1:fed_pkg::GAIN_W];
        w_next   = fed_pkg::sat_sample($signed({{2{s1_x_reg[SB-1]}}, s1_x_reg}) +
                                       $signed({scaled[SB], scaled}));
        out_next = fed_pkg::sat_sample($signed({{2{s1_x_reg[SB-1]}}, s1_x_reg}) +
                                       $signed({{2{d[SB-1]}}, d}));
    end

    always_comb
    begin
        mag_w      = s2_w_reg[SB-1] ? SB'(~s2_w_reg + 1'b1) : s2_w_reg;
        mag_old    = s2_old_reg[SB-1] ? SB'(~s2_old_reg + 1'b1) : s2_old_reg;
        delta_next = $signed({1'b0, mag_w}) - $signed({1'b0, mag_old});
    end

    always_comb
    begin
        level_next = level_reg +
                     {{(fed_pkg::SUM_W-SB-1){s3_delta_reg[SB]}}, s3_delta_reg};
        tail       = fed_pkg::CMP_W'(level_next) > fed_pkg::CMP_W'(cfg.thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wl_valid_reg <= 1'b0;
            level_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            wl_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wp_reg    <= req.wp;
        s1_rd_reg    <= req.rd;
        s1_x_reg     <= req.x;
        s2_wp_reg    <= s1_wp_reg;
        s2_w_reg     <= w_next;
        s2_old_reg   <= old;
        s2_out_reg   <= out_next;
        s3_out_reg   <= s2_out_reg;
        s3_delta_reg <= delta_next;
        wl_addr_reg  <= s2_wp_reg;
        wl_data_reg  <= s2_w_reg;
    end

    assign wr        = '{we: s2_valid_reg, addr: s2_wp_reg, data: s2_w_reg};
    assign res_valid = s3_valid_reg;
    assign res       = '{out_sample: s3_out_reg, tail: tail};
    assign inflight  = fed_pkg::INFL_W'(s1_valid_reg) + fed_pkg::INFL_W'(s2_valid_reg) +
                       fed_pkg::INFL_W'(s3_valid_reg);

endmodule

>>> src/fed_result_fifo.sv
`timescale 1ns / 1ps

module fed_result_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  fed_pkg::result_t            push_data,
    input  logic                        pop,
    output fed_pkg::result_t            head,
    output logic [fed_pkg::CNT_W-1:0]   count
);

    fed_pkg::result_t                 fifo_reg [fed_pkg::FIFO_DEPTH];
    logic [fed_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [fed_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [fed_pkg::CNT_W-1:0]        count_reg;
    logic [fed_pkg::CNT_W-1:0]        count_next;

    always_comb
    begin
        count_next = count_reg + fed_pkg::CNT_W'(push) - fed_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = fifo_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Tracks the echo ring, the pointer and the level sum, and queues the result
// expected for every request the block accepts.
class echo_checker;

    typedef struct {
        fed_pkg::sample_t out_sample;
        logic             tail;
    } echo_out_t;

    fed_pkg::sample_t ring [fed_pkg::RING_DEPTH];
    int unsigned      write_ptr;
    longint           level;

    logic [fed_pkg::GAIN_W-1:0]  gain;
    logic [fed_pkg::DELAY_W-1:0] delay;
    logic [fed_pkg::CHAN_W-1:0]  chan;
    logic [fed_pkg::THR_W-1:0]   thr;

    echo_out_t expected_out [$];
    int        mismatches;

    function new();
        foreach (ring[i])
        begin
            ring[i] = '0;
        end
        write_ptr  = 0;
        level      = 0;
        gain       = fed_pkg::GAIN_RST;
        delay      = fed_pkg::DELAY_RST;
        chan       = fed_pkg::CHAN_RST;
        thr        = fed_pkg::THR_RST;
        mismatches = 0;
    endfunction

    function void set_register(fed_pkg::cfg_reg_t idx,
                               logic [fed_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            fed_pkg::CFG_FEEDBACK_GAIN:  gain  = value[fed_pkg::GAIN_W-1:0];
            fed_pkg::CFG_DELAY_FRAMES:   delay = value[fed_pkg::DELAY_W-1:0];
            fed_pkg::CFG_CHANNEL_COUNT:  chan  = value[fed_pkg::CHAN_W-1:0];
            fed_pkg::CFG_TAIL_THRESHOLD: thr   = value[fed_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    function fed_pkg::sample_t clamp(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (fed_pkg::SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return fed_pkg::sample_t'(hi);
        if (v < lo)
            return fed_pkg::sample_t'(lo);
        return fed_pkg::sample_t'(v);
    endfunction

    function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function void note_sample(fed_pkg::sample_t x);
        int unsigned ch;
        int unsigned len;
        int unsigned rd;
        longint      delayed;
        longint      scaled;
        longint      stored;
        longint      old_word;
        echo_out_t   e;

        // channel count of zero acts as one, three acts as two
        ch = (chan == 0) ? 1 : ((chan > 2) ? 2 : chan);
        len = (int'(delay) + 1) * ch;
        if (len > fed_pkg::RING_DEPTH)
            len = fed_pkg::RING_DEPTH;
        if (write_ptr >= len)
            write_ptr = 0;

        rd = write_ptr + ch;
        if (rd >= len)
            rd -= len;
        delayed = ring[rd];

        // round to nearest, ties toward plus infinity
        scaled = (longint'(gain) * delayed + (longint'(1) << 14)) >>> 15;
        stored = clamp(x + scaled);
        old_word = ring[write_ptr];
        level = level - magnitude(old_word) + magnitude(stored);
        ring[write_ptr] = fed_pkg::sample_t'(stored);

        write_ptr++;
        if (write_ptr >= len)
            write_ptr = 0;

        e.out_sample = clamp(x + delayed);
        e.tail       = (level > longint'(thr));
        expected_out.push_back(e);
    endfunction

    function void check_output(fed_pkg::sample_t s, logic tail);
        echo_out_t e;
        if (expected_out.size() == 0)
        begin
            $display("%0t: result with nothing expected: out_sample %0d tail_active %0b",
                     $time, s, tail);
            mismatches++;
            return;
        end
        e = expected_out.pop_front();
        if (s !== e.out_sample)
        begin
            $display("%0t: out_sample expected %0d, actual %0d", $time, e.out_sample, s);
            mismatches++;
        end
        if (tail !== e.tail)
        begin
            $display("%0t: tail_active expected %0b, actual %0b", $time, e.tail, tail);
            mismatches++;
        end
    endfunction

endclass

module tb_top;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fed_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fed_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    fed_pkg::sample_t               in_sample;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    fed_pkg::sample_t               out_sample;
    logic                           tail_active;

    // While set, neither side idles: a long back-to-back stretch
    bit calm = 1'b0;

    echo_checker echoes;

    feedback_echo_delay dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_sample   (in_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_sample  (out_sample),
        .tail_active (tail_active)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop: far beyond the reset sweep plus the slowest stalled run
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Consumer: stall about 27 percent of the time, never during the calm stretch
    always @(posedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < 27);
    end

    // Monitor: note accepted requests first, then check accepted results.
    // Values read here are the ones settled before this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                echoes.note_sample(in_sample);
            if (out_valid && !out_stall)
                echoes.check_output(out_sample, tail_active);
        end
    end

    // Drive one register write; the caller lowers the write enable afterwards
    task automatic put_reg(fed_pkg::cfg_reg_t idx, logic [fed_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        echoes.set_register(idx, value);
    endtask

    // Write all four registers back to back; call only while drained
    task automatic apply_setting(int unsigned g, int unsigned d, int unsigned c,
                                 int unsigned t);
        put_reg(fed_pkg::CFG_FEEDBACK_GAIN, fed_pkg::CFG_DATA_W'(g));
        put_reg(fed_pkg::CFG_DELAY_FRAMES, fed_pkg::CFG_DATA_W'(d));
        put_reg(fed_pkg::CFG_CHANNEL_COUNT, fed_pkg::CFG_DATA_W'(c));
        put_reg(fed_pkg::CFG_TAIL_THRESHOLD, fed_pkg::CFG_DATA_W'(t));
        cfg_we <= 1'b0;
    endtask

    // Offer one request, with random idle slots ahead of it; hold the payload
    // until the block takes it. Valid stays high for a following request.
    task automatic send_sample(fed_pkg::sample_t x);
        while (!calm && ($urandom_range(99) < 27))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has come back,
    // then let the three-stage pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (echoes.expected_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mix of full-range values, both rails, small values and padding zeros
    function automatic fed_pkg::sample_t pick_sample();
        int unsigned r;
        int          v;
        r = $urandom_range(99);
        if (r < 40)
            return fed_pkg::sample_t'($urandom);
        if (r < 50)
            return 16'sh7fff;
        if (r < 60)
            return 16'sh8000;
        if (r < 85)
        begin
            v = int'($urandom_range(511)) - 256;
            return fed_pkg::sample_t'(v);
        end
        return '0;
    endfunction

    initial
    begin
        int          sent;
        int          phase;
        int          count;
        int unsigned g;
        int unsigned d;
        int unsigned c;
        int unsigned t;
        int unsigned r;

        echoes    = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = fed_pkg::CFG_FEEDBACK_GAIN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_sample = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Hold off until the ring clearing sweep lets go of the input
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        // Reset settings: long delay, so the delayed word reads as zero
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample('0);

        // Full gain, one-frame delay: drive both rails into saturation
        drain();
        apply_setting(32767, 1, 1, 0);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(-16'sh0001);

        // Zero delay and zero gain, threshold at its top
        drain();
        apply_setting(0, 0, 1, 32'h7fff_ffff);
        send_sample(16'sd12345);
        send_sample(-16'sh0001);
        send_sample(16'sh7fff);

        // Half gain on two channels with zero delay: rounding ties on odd words
        drain();
        apply_setting(16384, 0, 2, 100);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd5);
        send_sample(-16'sd5);

        // Channel count zero behaves as one channel; tiny gain
        drain();
        apply_setting(1, 2, 0, 1);
        send_sample(-16'sh0001);
        send_sample(16'sh0001);
        send_sample(16'sh8000);

        // Channel count three behaves as two channels
        drain();
        apply_setting(32767, 1, 3, 40000);
        send_sample(16'sd30000);
        send_sample(-16'sd30000);

        // Random phases, each with its own full setting
        sent  = 0;
        phase = 0;
        while (sent < 1600)
        begin
            r = $urandom_range(99);
            g = (r < 10) ? 0 : ((r < 20) ? 32767 : $urandom_range(32767));
            r = $urandom_range(99);
            if (r < 70)
                d = $urandom_range(12);
            else if (r < 90)
                d = $urandom_range(200, 13);
            else
                d = $urandom_range(32767, 201);
            c = $urandom_range(3);
            r = $urandom_range(99);
            if (r < 20)
                t = 0;
            else if (r < 30)
                t = 32'h7fff_ffff;
            else
                t = $urandom_range(1 << $urandom_range(20, 4));
            count = $urandom_range(150, 30);

            // Ring capped at the store depth, then a short ring next phase
            // so the pointer is left past the end and restarts
            if (phase == 0)
            begin
                d     = 32767;
                c     = 2;
                count = 40;
            end
            else if (phase == 1)
            begin
                d = $urandom_range(6);
                c = 1;
            end

            calm = (phase == 5);
            if (calm)
                count = 250;

            drain();
            apply_setting(g, d, c, t);
            for (int i = 0; i < count; i++)
                send_sample(pick_sample());
            sent += count;
            phase++;
        end

        calm = 1'b0;
        drain();

        if (echoes.mismatches == 0 && echoes.expected_out.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
